// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define ERFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold on the edge after the trigger holds.
`define ERFD_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/erfd_pkg.sv =====
// Types and constants shared by the escaped register frame decoder.
package erfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_LANES = 4;
    localparam int WORD_W     = BYTE_W * WORD_LANES;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR    = 2'd2;

    localparam logic [BYTE_W-1:0] HEAD_RESET   = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
    localparam logic [BYTE_W-1:0] XOR_RESET    = 8'd32;
    localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd2;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_LEN,
        PH_INDEX,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]        target_index;
        logic signed [WORD_W-1:0] word_value;
        logic                     frame_status;
    } t_result;

endpackage

// ===== rtl/escaped_register_frame_decoder.sv =====
// Top level of the escaped register frame decoder.
//
// Received bytes enter on the s_axis channel, one byte per beat in tdata.
// A frame is a head byte, a length byte, the register index, escaped data
// bytes and an additive checksum. Each finished frame leaves as one beat on
// the m_axis channel: tdata carries the index and the big-endian data word,
// tuser carries the status (0 checksum good, 1 checksum mismatch).
// Registers head_value, escape_value and escape_xor are written through the cfg
// port (index 0, 1, 2); the user must write them only while no frame is in
// progress, as the block does not enforce it. Throughput is one byte per cycle
// while s_axis_tready is high; the per-byte update is a single pass of the phase
// machine. The result beat is registered once the checksum byte is accepted.
// A result register and a skid entry sit in front of m_axis, so a stalled
// receiver does not stop input until two results are waiting; then
// s_axis_tready falls until the receiver takes a beat.
// Reset restores the register defaults, drops any partial frame and empties
// the output stage.
module escaped_register_frame_decoder #(
    parameter int WORD_BYTES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [erfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [erfd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,  // target_index, word_value
    output logic                            m_axis_tuser   // frame_status
);

    logic              w_accept;
    logic              w_in_ready;
    logic              w_res_valid;
    erfd_pkg::t_result w_res;
    erfd_pkg::t_result w_out;

    assign w_accept      = s_axis_tvalid && w_in_ready;
    assign s_axis_tready = w_in_ready;

    erfd_core #(
        .WORD_BYTES(WORD_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_rx_byte   (s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    erfd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_res_valid),
        .i_res      (w_res),
        .o_in_ready (w_in_ready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_out)
    );

    assign m_axis_tdata = {w_out.word_value, w_out.target_index};
    assign m_axis_tuser = w_out.frame_status;

endmodule

// ===== rtl/erfd_core.sv =====
// Frame parser: configuration registers, phase machine, unescaping and checksum.
`include "assert_macros.svh"

module erfd_core #(
    parameter int WORD_BYTES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [erfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [erfd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_accept,
    input  logic [erfd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_res_valid,
    output erfd_pkg::t_result               o_res
);

    localparam int PLACE_BYTES = (WORD_BYTES < erfd_pkg::WORD_LANES) ?
                                 WORD_BYTES : erfd_pkg::WORD_LANES;
    localparam int CNT_W = $clog2(PLACE_BYTES + 1);

    logic [erfd_pkg::BYTE_W-1:0] r_head, r_escape, r_xor;

    erfd_pkg::t_phase            r_phase, n_phase;
    logic [erfd_pkg::BYTE_W-1:0] r_left, n_left;
    logic [erfd_pkg::BYTE_W-1:0] r_sum, n_sum;
    logic [erfd_pkg::BYTE_W-1:0] r_index, n_index;
    logic [erfd_pkg::WORD_W-1:0] r_word, n_word;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_esc, n_esc;

    logic                        w_place;
    logic [erfd_pkg::BYTE_W-1:0] w_place_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= erfd_pkg::HEAD_RESET;
            r_escape <= erfd_pkg::ESCAPE_RESET;
            r_xor    <= erfd_pkg::XOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                erfd_pkg::CFG_HEAD:   r_head   <= i_cfg_data;
                erfd_pkg::CFG_ESCAPE: r_escape <= i_cfg_data;
                erfd_pkg::CFG_XOR:    r_xor    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= erfd_pkg::PH_HEAD;
            r_left  <= '0;
            r_sum   <= '0;
            r_index <= '0;
            r_word  <= '0;
            r_count <= '0;
            r_esc   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_sum   <= n_sum;
            r_index <= n_index;
            r_word  <= n_word;
            r_count <= n_count;
            r_esc   <= n_esc;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_left       = r_left;
        n_sum        = r_sum;
        n_index      = r_index;
        n_word       = r_word;
        n_count      = r_count;
        n_esc        = r_esc;
        w_place      = 1'b0;
        w_place_byte = i_rx_byte;
        o_res_valid  = 1'b0;

        if (i_accept) begin
            unique case (r_phase)
                erfd_pkg::PH_HEAD: begin
                    if (i_rx_byte == r_head) begin
                        n_phase = erfd_pkg::PH_LEN;
                    end
                end
                erfd_pkg::PH_LEN: begin
                    if (i_rx_byte < erfd_pkg::MIN_LENGTH) begin
                        n_phase = erfd_pkg::PH_HEAD;
                    end else begin
                        n_left  = i_rx_byte;
                        n_phase = erfd_pkg::PH_INDEX;
                    end
                end
                erfd_pkg::PH_INDEX: begin
                    n_index = i_rx_byte;
                    n_sum   = i_rx_byte;
                    n_left  = r_left - 8'd1;
                    n_word  = '0;
                    n_count = '0;
                    n_esc   = 1'b0;
                    n_phase = erfd_pkg::PH_DATA;
                end
                erfd_pkg::PH_DATA: begin
                    if (r_left <= 8'd1) begin
                        o_res_valid = 1'b1;
                        n_esc       = 1'b0;
                        n_left      = '0;
                        n_phase     = erfd_pkg::PH_HEAD;
                    end else begin
                        n_sum  = r_sum + i_rx_byte;
                        n_left = r_left - 8'd1;
                        if (r_esc) begin
                            n_esc        = 1'b0;
                            w_place      = 1'b1;
                            w_place_byte = i_rx_byte ^ r_xor;
                        end else if (i_rx_byte == r_escape) begin
                            n_esc = 1'b1;
                        end else begin
                            w_place = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Decoded bytes fill the word from the most significant lane down.
        if (w_place && (r_count < CNT_W'(PLACE_BYTES))) begin
            for (int k = 0; k < PLACE_BYTES; k++) begin
                if (r_count == CNT_W'(k)) begin
                    n_word[erfd_pkg::BYTE_W*(erfd_pkg::WORD_LANES-1-k) +: erfd_pkg::BYTE_W] =
                        w_place_byte;
                end
            end
            n_count = r_count + CNT_W'(1);
        end
    end

    assign o_res.target_index = r_index;
    assign o_res.word_value   = r_word;
    assign o_res.frame_status = (i_rx_byte != r_sum);

    `ERFD_ASSERT(a_res_in_data, i_clk, i_rst_n,
        !o_res_valid || (i_accept && r_phase == erfd_pkg::PH_DATA),
        "result raised outside an accepted data beat")
    `ERFD_ASSERT_NEXT(a_res_ends_frame, i_clk, i_rst_n, o_res_valid,
        r_phase == erfd_pkg::PH_HEAD && r_left == '0,
        "frame did not close after its checksum beat")
    `ERFD_ASSERT_NEXT(a_short_drop, i_clk, i_rst_n,
        i_accept && r_phase == erfd_pkg::PH_LEN && i_rx_byte < erfd_pkg::MIN_LENGTH,
        r_phase == erfd_pkg::PH_HEAD,
        "short length did not drop the frame")

endmodule

// ===== rtl/erfd_out_reg.sv =====
// Result register with a skid entry between the parser and the output channel.
`include "assert_macros.svh"

module erfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  erfd_pkg::t_result i_res,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output erfd_pkg::t_result o_res
);

    logic              r_out_valid, r_skid_valid;
    erfd_pkg::t_result r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    `ERFD_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid,
        "skid entry holds a beat while the output register is empty")
    `ERFD_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && r_skid_valid),
        "result pushed while both entries are full")
    `ERFD_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, r_out_valid && !i_ready,
        r_out_valid && r_out == $past(r_out),
        "stalled result beat changed or vanished")

endmodule
